FILE: design/tga_pkg.sv
// Shared types and constants for the TGA true-color decoder.
// Used by tga_parser, tga_out_fifo and the top level; no dependencies.
`default_nettype none

package tga_pkg;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 3;

    localparam logic [2:0] ST_PIXEL     = 3'd0;
    localparam logic [2:0] ST_TOO_SMALL = 3'd1;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd2;
    localparam logic [2:0] ST_BAD_DEPTH = 3'd3;
    localparam logic [2:0] ST_TRUNCATED = 3'd4;

    localparam logic [7:0] TYPE_TRUECOLOR = 8'd2;
    localparam logic [4:0] HEADER_LAST    = 5'd17;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] column;
        logic [15:0] row;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        final_pixel;
    } result_t;

    typedef struct packed {
        logic push0;
        logic push1;
    } push_t;

endpackage

`default_nettype wire

FILE: design/tga_parser.sv
// Header parser and pixel gatherer: holds the decoder state and turns one byte
// into up to two results. Depends on tga_pkg.
`default_nettype none

module tga_parser (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_eof,
    output tga_pkg::push_t         push,
    output tga_pkg::result_t       item0,
    output tga_pkg::result_t       item1
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_SKIP   = 2'd1;
    localparam logic [1:0] PH_PIXEL  = 2'd2;
    localparam logic [1:0] PH_IDLE   = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [4:0]  header_count_reg, header_count_next;
    logic [7:0]  id_length_reg, id_length_next;
    logic [7:0]  type_code_reg, type_code_next;
    logic [15:0] image_width_reg, image_width_next;
    logic [15:0] image_height_reg, image_height_next;
    logic [2:0]  bpp_reg, bpp_next;
    logic [1:0]  channel_index_reg, channel_index_next;
    logic [23:0] channel_bytes_reg, channel_bytes_next;
    logic [15:0] column_count_reg, column_count_next;
    logic [15:0] row_count_reg, row_count_next;

    logic [23:0]      gathered;
    logic [4:0]       depth_bytes;
    logic             pixel_done;
    logic             last_col;
    logic             last_row;
    logic             hdr_err;
    logic [2:0]       hdr_code;
    logic             trunc;
    tga_pkg::result_t pixel;
    tga_pkg::result_t err;

    always_comb begin
        phase_next         = phase_reg;
        header_count_next  = header_count_reg;
        id_length_next     = id_length_reg;
        type_code_next     = type_code_reg;
        image_width_next   = image_width_reg;
        image_height_next  = image_height_reg;
        bpp_next           = bpp_reg;
        channel_index_next = channel_index_reg;
        channel_bytes_next = channel_bytes_reg;
        column_count_next  = column_count_reg;
        row_count_next     = row_count_reg;
        hdr_err            = 1'b0;
        hdr_code           = tga_pkg::ST_TOO_SMALL;
        pixel_done         = 1'b0;
        depth_bytes        = in_byte[7:3];

        gathered = channel_bytes_reg;
        unique case (channel_index_reg)
            2'd0: gathered[7:0]   = in_byte;
            2'd1: gathered[15:8]  = in_byte;
            2'd2: gathered[23:16] = in_byte;
            default: gathered = channel_bytes_reg;
        endcase

        last_col = column_count_reg == (image_width_reg - 16'd1);
        last_row = row_count_reg == (image_height_reg - 16'd1);

        if (in_valid) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    unique case (header_count_reg)
                        5'd0:  id_length_next = in_byte;
                        5'd2:  type_code_next = in_byte;
                        5'd12: image_width_next[7:0]   = in_byte;
                        5'd13: image_width_next[15:8]  = in_byte;
                        5'd14: image_height_next[7:0]  = in_byte;
                        5'd15: image_height_next[15:8] = in_byte;
                        5'd16: begin
                            if (depth_bytes == 5'd3 || depth_bytes == 5'd4) begin
                                bpp_next = depth_bytes[2:0];
                            end else begin
                                bpp_next = 3'd0;
                            end
                        end
                        default: ;
                    endcase
                    if (header_count_reg >= tga_pkg::HEADER_LAST) begin
                        if (type_code_reg != tga_pkg::TYPE_TRUECOLOR) begin
                            hdr_err    = 1'b1;
                            hdr_code   = tga_pkg::ST_BAD_TYPE;
                            phase_next = PH_IDLE;
                        end else if (bpp_reg == 3'd0) begin
                            hdr_err    = 1'b1;
                            hdr_code   = tga_pkg::ST_BAD_DEPTH;
                            phase_next = PH_IDLE;
                        end else if (image_width_reg == 16'd0 || image_height_reg == 16'd0) begin
                            phase_next = PH_IDLE;
                        end else if (id_length_reg != 8'd0) begin
                            phase_next = PH_SKIP;
                        end else begin
                            phase_next = PH_PIXEL;
                        end
                    end else begin
                        header_count_next = header_count_reg + 5'd1;
                        if (in_eof) begin
                            hdr_err  = 1'b1;
                            hdr_code = tga_pkg::ST_TOO_SMALL;
                        end
                    end
                end
                PH_SKIP: begin
                    id_length_next = id_length_reg - 8'd1;
                    if (id_length_reg == 8'd1) begin
                        phase_next = PH_PIXEL;
                    end
                end
                PH_PIXEL: begin
                    if ({1'b0, channel_index_reg} + 3'd1 >= bpp_reg) begin
                        pixel_done         = 1'b1;
                        channel_index_next = 2'd0;
                        channel_bytes_next = 24'd0;
                        if (last_col) begin
                            column_count_next = 16'd0;
                            if (last_row) begin
                                phase_next = PH_IDLE;
                            end else begin
                                row_count_next = row_count_reg + 16'd1;
                            end
                        end else begin
                            column_count_next = column_count_reg + 16'd1;
                        end
                    end else begin
                        channel_index_next = channel_index_reg + 2'd1;
                        channel_bytes_next = gathered;
                    end
                end
                PH_IDLE: ;
                default: ;
            endcase
        end

        trunc = in_valid && in_eof && (phase_next == PH_SKIP || phase_next == PH_PIXEL);

        if (in_valid && in_eof) begin
            phase_next         = PH_HEADER;
            header_count_next  = 5'd0;
            id_length_next     = 8'd0;
            type_code_next     = 8'd0;
            image_width_next   = 16'd0;
            image_height_next  = 16'd0;
            bpp_next           = 3'd0;
            channel_index_next = 2'd0;
            channel_bytes_next = 24'd0;
            column_count_next  = 16'd0;
            row_count_next     = 16'd0;
        end
    end

    always_comb begin
        pixel.status      = tga_pkg::ST_PIXEL;
        pixel.column      = column_count_reg;
        pixel.row         = image_height_reg - 16'd1 - row_count_reg;
        pixel.red         = gathered[23:16];
        pixel.green       = gathered[15:8];
        pixel.blue        = gathered[7:0];
        pixel.alpha       = (bpp_reg == 3'd4) ? in_byte : 8'hFF;
        pixel.final_pixel = last_col && last_row;

        err        = '0;
        err.status = hdr_err ? hdr_code : tga_pkg::ST_TRUNCATED;

        if (pixel_done) begin
            push.push0 = 1'b1;
            push.push1 = trunc;
            item0      = pixel;
        end else begin
            push.push0 = hdr_err || trunc;
            push.push1 = 1'b0;
            item0      = err;
        end
        item1        = '0;
        item1.status = tga_pkg::ST_TRUNCATED;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_HEADER;
            header_count_reg  <= 5'd0;
            id_length_reg     <= 8'd0;
            type_code_reg     <= 8'd0;
            image_width_reg   <= 16'd0;
            image_height_reg  <= 16'd0;
            bpp_reg           <= 3'd0;
            channel_index_reg <= 2'd0;
            channel_bytes_reg <= 24'd0;
            column_count_reg  <= 16'd0;
            row_count_reg     <= 16'd0;
        end else begin
            phase_reg         <= phase_next;
            header_count_reg  <= header_count_next;
            id_length_reg     <= id_length_next;
            type_code_reg     <= type_code_next;
            image_width_reg   <= image_width_next;
            image_height_reg  <= image_height_next;
            bpp_reg           <= bpp_next;
            channel_index_reg <= channel_index_next;
            channel_bytes_reg <= channel_bytes_next;
            column_count_reg  <= column_count_next;
            row_count_reg     <= row_count_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/tga_out_fifo.sv
// Result queue that takes up to two results per cycle and hands out one per transfer.
// Depends on tga_pkg.
`default_nettype none

module tga_out_fifo (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  tga_pkg::push_t         push,
    input  tga_pkg::result_t       item0,
    input  tga_pkg::result_t       item1,
    output logic                   room,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output tga_pkg::result_t       out_item
);

    tga_pkg::result_t mem_reg [tga_pkg::FIFO_DEPTH];

    logic [tga_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tga_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [tga_pkg::FIFO_CNT_W-1:0] count_reg, count_next;
    logic [tga_pkg::FIFO_CNT_W-1:0] after_pop;
    logic [tga_pkg::FIFO_PTR_W-1:0] wr_ptr_plus;
    logic                           pop;

    always_comb begin
        out_valid   = count_reg != '0;
        out_item    = mem_reg[rd_ptr_reg];
        pop         = out_valid && out_ready;
        after_pop   = count_reg - {{(tga_pkg::FIFO_CNT_W-1){1'b0}}, pop};
        room        = after_pop <= tga_pkg::FIFO_CNT_W'(tga_pkg::FIFO_DEPTH - 2);
        wr_ptr_plus = wr_ptr_reg + 1'b1;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg
                      + {{(tga_pkg::FIFO_PTR_W-1){1'b0}}, push.push0}
                      + {{(tga_pkg::FIFO_PTR_W-1){1'b0}}, push.push1};
        count_next  = after_pop
                      + {{(tga_pkg::FIFO_CNT_W-1){1'b0}}, push.push0}
                      + {{(tga_pkg::FIFO_CNT_W-1){1'b0}}, push.push1};
    end

    always_ff @(posedge aclk) begin
        if (push.push0) begin
            mem_reg[wr_ptr_reg] <= item0;
        end
        if (push.push1) begin
            mem_reg[wr_ptr_plus] <= item1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/tga_uncompressed_truecolor_decoder.sv
// Top level of the TGA true-color decoder: input register, parser and result queue.
// Depends on tga_pkg, tga_parser and tga_out_fifo.
// A byte is taken every cycle unless the input register is full and the queue lacks
// room for two more results; its results pass through the input register and the result queue.
// A byte that completes a pixel other than the last at the end of the file gives
// two results, pixel then truncation, which leave via a four-entry result queue.
// Reset (synchronous, active low) returns the parser to the header and empties the queue.
`default_nettype none

module tga_uncompressed_truecolor_decoder (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [tga_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] file_byte
    input  wire logic                          s_tlast,  // end_of_file
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [15:0] column, [31:16] row, [39:32] red, [47:40] green,
    // [55:48] blue, [63:56] alpha
    output logic [tga_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [tga_pkg::M_TUSER_W-1:0]      m_tuser,  // [2:0] status
    output logic                               m_tlast   // final_pixel
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_eof_reg;
    logic       room;
    logic       process;
    logic       s_accept;

    tga_pkg::push_t   push;
    tga_pkg::result_t item0;
    tga_pkg::result_t item1;
    tga_pkg::result_t out_item;

    always_comb begin
        process       = in_valid_reg && room;
        s_tready      = !in_valid_reg || room;
        s_accept      = s_tvalid && s_tready;
        in_valid_next = s_accept || (in_valid_reg && !process);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata[7:0];
            in_eof_reg  <= s_tlast;
        end
    end

    tga_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (process),
        .in_byte  (in_byte_reg),
        .in_eof   (in_eof_reg),
        .push     (push),
        .item0    (item0),
        .item1    (item1)
    );

    tga_out_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .item0     (item0),
        .item1     (item1),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = {out_item.alpha, out_item.blue, out_item.green, out_item.red,
                      out_item.row, out_item.column};
    assign m_tuser = out_item.status;
    assign m_tlast = out_item.final_pixel;

endmodule

`default_nettype wire
